### hw/rtl/tsto_pkg.sv
// ----------------------------------------------------------------------------
// TCP SYN timeout tracker package
// Shared constants, codes and item types of the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tsto_pkg;

    localparam int ATTEMPT_ENTRIES = 32;
    localparam int FAILURE_ENTRIES = 64;
    localparam int ATT_IW  = (ATTEMPT_ENTRIES > 1) ? $clog2(ATTEMPT_ENTRIES) : 1;
    localparam int FAIL_IW = (FAILURE_ENTRIES > 1) ? $clog2(FAILURE_ENTRIES) : 1;
    localparam int FAIL_W  = 96;

    localparam logic [3:0] LINEAR_RESET = 4'd4;
    localparam logic [3:0] SPAN_RESET   = 4'd6;
    localparam logic [31:0] LINEAR_DELAY = 32'd2;

    localparam logic [0:0] REG_LINEAR = 1'b0;
    localparam logic [0:0] REG_SPAN   = 1'b1;

    localparam logic [1:0] CMD_SYN    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_RETRY     = 3'd1;
    localparam logic [2:0] KIND_REMOVED   = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_FULL      = 3'd4;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd5;
    localparam logic [2:0] KIND_TICK_DONE = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] total;
        logic [7:0]  retry;
        logic        ffull;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/tsto_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tsto_front.sv
// ----------------------------------------------------------------------------
// Tracker front end
// Accepts input beats, drops unknown commands and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module tsto_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tsto_pkg::item_t in_item,
    output logic                q_valid,
    input  wire logic           q_ready,
    output tsto_pkg::item_t     q_item
);

    tsto_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready && (in_item.cmd != tsto_pkg::CMD_NONE);
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tsto_back.sv
// ----------------------------------------------------------------------------
// Tracker back end
// Holds the attempt table and the failure RAM and works through one queued
// item at a time, loading results into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsto_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [0:0]      cfg_wr_index,
    input  wire logic [3:0]      cfg_wr_data,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire tsto_pkg::item_t q_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tsto_pkg::result_t    out_res
);

    localparam int ATT  = tsto_pkg::ATTEMPT_ENTRIES;
    localparam int FAIL = tsto_pkg::FAILURE_ENTRIES;
    localparam int AIW  = tsto_pkg::ATT_IW;
    localparam int FIW  = tsto_pkg::FAIL_IW;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_ACT, T_DLY, T_CMP, F_RD, F_CK, F_END, T_EMIT, T_DONE
    } state_t;

    state_t state_reg;

    logic [3:0]  linear_reg;
    logic [3:0]  span_reg;
    logic [31:0] seconds_reg;
    tsto_pkg::item_t item_reg;

    logic        att_valid_reg [ATT];
    logic [31:0] att_src_reg   [ATT];
    logic [31:0] att_dst_reg   [ATT];
    logic [31:0] att_ports_reg [ATT];
    logic [7:0]  att_retry_reg [ATT];
    logic [31:0] att_stamp_reg [ATT];
    logic        fail_valid_reg [FAIL];

    logic           hit_reg;
    logic           free_ok_reg;
    logic [AIW-1:0] hit_idx_reg;
    logic [AIW-1:0] free_idx_reg;
    logic [AIW-1:0] sweep_idx_reg;
    logic [FIW-1:0] fidx_reg;
    logic [31:0]    delay_reg;
    logic [31:0]    age_reg;
    logic [15:0]    total_reg;
    logic           ffull_reg;

    logic           out_valid_reg;
    tsto_pkg::result_t res_reg;

    logic           hit_c;
    logic [AIW-1:0] hit_idx_c;
    logic           free_ok_c;
    logic [AIW-1:0] free_idx_c;
    logic           ffree_ok_c;
    logic [FIW-1:0] ffree_idx_c;
    logic [AIW-1:0] rd_idx;
    logic [7:0]     rd_retry;
    logic [8:0]     lin_span;
    logic [7:0]     k_full;
    logic [31:0]    delay_c;
    logic           out_free;
    logic           out_load;
    logic           sweep_last;
    logic           fidx_last;
    logic [15:0]    sat_cnt;

    logic                 ram_wr_en;
    logic [FIW-1:0]       ram_wr_addr;
    logic [tsto_pkg::FAIL_W-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [tsto_pkg::FAIL_W-1:0] ram_rd_data;
    logic                 fail_match;

    assign out_valid  = out_valid_reg;
    assign out_res    = res_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_load   = out_free && (state_reg inside {S_ACT, T_EMIT, T_DONE});
    assign q_ready    = (state_reg == S_IDLE);
    assign sweep_last = (sweep_idx_reg == AIW'(ATT - 1));
    assign fidx_last  = (fidx_reg == FIW'(FAIL - 1));

    // Lookup over all slots; only one slot can ever hold a given tuple.
    always_comb begin
        hit_c      = 1'b0;
        hit_idx_c  = '0;
        free_ok_c  = 1'b0;
        free_idx_c = '0;
        for (int i = ATT - 1; i >= 0; i--) begin
            if (att_valid_reg[i] && att_src_reg[i] == item_reg.src &&
                att_dst_reg[i] == item_reg.dst &&
                att_ports_reg[i] == {item_reg.sport, item_reg.dport}) begin
                hit_c     = 1'b1;
                hit_idx_c = AIW'(i);
            end
            if (!att_valid_reg[i]) begin
                free_ok_c  = 1'b1;
                free_idx_c = AIW'(i);
            end
        end
    end

    always_comb begin
        ffree_ok_c  = 1'b0;
        ffree_idx_c = '0;
        for (int j = FAIL - 1; j >= 0; j--) begin
            if (!fail_valid_reg[j]) begin
                ffree_ok_c  = 1'b1;
                ffree_idx_c = FIW'(j);
            end
        end
    end

    assign rd_idx   = (state_reg == S_ACT) ? hit_idx_reg : sweep_idx_reg;
    assign rd_retry = att_retry_reg[rd_idx];
    assign lin_span = {5'd0, linear_reg} + {5'd0, span_reg};
    assign k_full   = rd_retry - {4'd0, linear_reg};

    always_comb begin
        if (rd_retry < {4'd0, linear_reg}) begin
            delay_c = tsto_pkg::LINEAR_DELAY;
        end else if ({1'b0, rd_retry} <= lin_span) begin
            delay_c = (32'd1 << k_full[4:0]) + 32'd1;
        end else begin
            delay_c = 32'd1;
        end
    end

    assign fail_match = (ram_rd_data[95:32] == {att_src_reg[sweep_idx_reg],
                                                att_dst_reg[sweep_idx_reg]}) &&
                        (ram_rd_data[31:16] == att_ports_reg[sweep_idx_reg][15:0]);
    assign sat_cnt = (ram_rd_data[15:0] == 16'hFFFF) ? 16'hFFFF
                                                     : ram_rd_data[15:0] + 16'd1;

    assign ram_rd_en   = (state_reg == F_RD) && fail_valid_reg[fidx_reg];
    assign ram_wr_en   = ((state_reg == F_CK) && fail_match) ||
                         ((state_reg == F_END) && ffree_ok_c);
    assign ram_wr_addr = (state_reg == F_CK) ? fidx_reg : ffree_idx_c;
    assign ram_wr_data = (state_reg == F_CK) ? {ram_rd_data[95:16], sat_cnt}
                       : {att_src_reg[sweep_idx_reg], att_dst_reg[sweep_idx_reg],
                          att_ports_reg[sweep_idx_reg][15:0], 16'd1};

    tsto_ram #(
        .WIDTH (tsto_pkg::FAIL_W),
        .DEPTH (FAIL)
    ) u_fail_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (fidx_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            linear_reg    <= tsto_pkg::LINEAR_RESET;
            span_reg      <= tsto_pkg::SPAN_RESET;
            seconds_reg   <= 32'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ATT; i++) begin
                att_valid_reg[i] <= 1'b0;
            end
            for (int j = 0; j < FAIL; j++) begin
                fail_valid_reg[j] <= 1'b0;
            end
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == tsto_pkg::REG_LINEAR) begin
                    linear_reg <= cfg_wr_data;
                end else begin
                    span_reg <= cfg_wr_data;
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg <= q_item;
                        if (q_item.cmd == tsto_pkg::CMD_TICK) begin
                            seconds_reg   <= seconds_reg + 32'd1;
                            sweep_idx_reg <= '0;
                            state_reg     <= T_DLY;
                        end else begin
                            state_reg <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    hit_reg      <= hit_c;
                    hit_idx_reg  <= hit_idx_c;
                    free_ok_reg  <= free_ok_c;
                    free_idx_reg <= free_idx_c;
                    state_reg    <= S_ACT;
                end
                S_ACT: begin
                    if (out_free) begin
                        res_reg.src   <= item_reg.src;
                        res_reg.dst   <= item_reg.dst;
                        res_reg.sport <= item_reg.sport;
                        res_reg.dport <= item_reg.dport;
                        res_reg.total <= 16'd0;
                        res_reg.ffull <= 1'b0;
                        res_reg.last  <= 1'b1;
                        if (item_reg.cmd == tsto_pkg::CMD_SYN) begin
                            if (hit_reg) begin
                                att_retry_reg[hit_idx_reg] <= (rd_retry == 8'hFF) ? 8'hFF
                                                              : rd_retry + 8'd1;
                                att_stamp_reg[hit_idx_reg] <= seconds_reg;
                                res_reg.kind  <= tsto_pkg::KIND_RETRY;
                                res_reg.retry <= (rd_retry == 8'hFF) ? 8'hFF
                                                 : rd_retry + 8'd1;
                            end else if (free_ok_reg) begin
                                att_valid_reg[free_idx_reg] <= 1'b1;
                                att_src_reg[free_idx_reg]   <= item_reg.src;
                                att_dst_reg[free_idx_reg]   <= item_reg.dst;
                                att_ports_reg[free_idx_reg] <= {item_reg.sport,
                                                                item_reg.dport};
                                att_retry_reg[free_idx_reg] <= 8'd0;
                                att_stamp_reg[free_idx_reg] <= seconds_reg;
                                res_reg.kind  <= tsto_pkg::KIND_ADDED;
                                res_reg.retry <= 8'd0;
                            end else begin
                                res_reg.kind  <= tsto_pkg::KIND_FULL;
                                res_reg.retry <= 8'd0;
                            end
                        end else begin
                            if (hit_reg) begin
                                att_valid_reg[hit_idx_reg] <= 1'b0;
                                res_reg.kind  <= tsto_pkg::KIND_REMOVED;
                                res_reg.retry <= rd_retry;
                            end else begin
                                res_reg.kind  <= tsto_pkg::KIND_NOT_FOUND;
                                res_reg.retry <= 8'd0;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                T_DLY: begin
                    if (att_valid_reg[sweep_idx_reg]) begin
                        delay_reg <= delay_c;
                        age_reg   <= seconds_reg - att_stamp_reg[sweep_idx_reg];
                        state_reg <= T_CMP;
                    end else if (sweep_last) begin
                        state_reg <= T_DONE;
                    end else begin
                        sweep_idx_reg <= sweep_idx_reg + AIW'(1);
                    end
                end
                T_CMP: begin
                    if (age_reg > delay_reg) begin
                        fidx_reg  <= '0;
                        state_reg <= F_RD;
                    end else if (sweep_last) begin
                        state_reg <= T_DONE;
                    end else begin
                        sweep_idx_reg <= sweep_idx_reg + AIW'(1);
                        state_reg     <= T_DLY;
                    end
                end
                F_RD: begin
                    if (fail_valid_reg[fidx_reg]) begin
                        state_reg <= F_CK;
                    end else if (fidx_last) begin
                        state_reg <= F_END;
                    end else begin
                        fidx_reg <= fidx_reg + FIW'(1);
                    end
                end
                F_CK: begin
                    if (fail_match) begin
                        total_reg <= sat_cnt;
                        ffull_reg <= 1'b0;
                        state_reg <= T_EMIT;
                    end else if (fidx_last) begin
                        state_reg <= F_END;
                    end else begin
                        fidx_reg  <= fidx_reg + FIW'(1);
                        state_reg <= F_RD;
                    end
                end
                F_END: begin
                    if (ffree_ok_c) begin
                        fail_valid_reg[ffree_idx_c] <= 1'b1;
                        total_reg <= 16'd1;
                        ffull_reg <= 1'b0;
                    end else begin
                        total_reg <= 16'd0;
                        ffull_reg <= 1'b1;
                    end
                    state_reg <= T_EMIT;
                end
                T_EMIT: begin
                    if (out_free) begin
                        res_reg.kind  <= tsto_pkg::KIND_TIMEOUT;
                        res_reg.src   <= att_src_reg[sweep_idx_reg];
                        res_reg.dst   <= att_dst_reg[sweep_idx_reg];
                        res_reg.sport <= att_ports_reg[sweep_idx_reg][31:16];
                        res_reg.dport <= att_ports_reg[sweep_idx_reg][15:0];
                        res_reg.total <= total_reg;
                        res_reg.retry <= rd_retry;
                        res_reg.ffull <= ffull_reg;
                        res_reg.last  <= 1'b0;
                        att_valid_reg[sweep_idx_reg] <= 1'b0;
                        if (sweep_last) begin
                            state_reg <= T_DONE;
                        end else begin
                            sweep_idx_reg <= sweep_idx_reg + AIW'(1);
                            state_reg     <= T_DLY;
                        end
                    end
                end
                T_DONE: begin
                    if (out_free) begin
                        res_reg.kind  <= tsto_pkg::KIND_TICK_DONE;
                        res_reg.src   <= 32'd0;
                        res_reg.dst   <= 32'd0;
                        res_reg.sport <= 16'd0;
                        res_reg.dport <= 16'd0;
                        res_reg.total <= 16'd0;
                        res_reg.retry <= 8'd0;
                        res_reg.ffull <= 1'b0;
                        res_reg.last  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tcp_syn_timeout_tracker_unit.sv
// ----------------------------------------------------------------------------
// TCP SYN timeout tracker
// Tracks pending connection attempts and counts those that time out.
// ----------------------------------------------------------------------------
// Usage: the s_ channel carries one command per beat (SYN, remove or a
// one-second tick) with the connection tuple; the m_ channel returns results,
// with m_tlast on the final result of each command. Unknown commands are
// absorbed without a result. Configuration writes go through cfg_wr_en.
// A SYN or remove goes through three steps from the queue to a valid result:
// latch, the parallel compare over all attempt slots, then update and load
// the output register; the engine takes no new command until it is done.
// A tick sweeps every attempt slot, and each timeout scans the failure RAM
// entry by entry through its single read port.
// A two-beat queue lets the input side run on while the engine is busy.
// When the receiver stalls, the result is held in the output register and the
// engine waits. Reset clears both tables, the seconds counter and the queue,
// and restores the registers to their defaults; no clearing pass is needed.
`default_nettype none

module tcp_syn_timeout_tracker_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // source_address, dest_address, source_port, dest_port
    input  wire logic [95:0]  s_tdata,
    // cmd
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_source_address, out_dest_address, out_source_port, out_dest_port,
    // failure_total, retry_value, failure_table_full, zero padding
    output logic [127:0]      m_tdata,
    // kind
    output logic [2:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [0:0]   cfg_wr_index,
    input  wire logic [3:0]   cfg_wr_data
);

    tsto_pkg::item_t   in_item;
    tsto_pkg::item_t   q_item;
    tsto_pkg::result_t res;
    logic              q_valid;
    logic              q_ready;

    assign in_item.cmd   = s_tuser;
    assign in_item.src   = s_tdata[31:0];
    assign in_item.dst   = s_tdata[63:32];
    assign in_item.sport = s_tdata[79:64];
    assign in_item.dport = s_tdata[95:80];

    tsto_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    tsto_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_res      (res)
    );

    assign m_tdata = {7'd0, res.ffull, res.retry, res.total, res.dport, res.sport,
                      res.dst, res.src};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

### hw/rtl/tsto_checker.sv
// ----------------------------------------------------------------------------
// Tracker port checker
// Watches the result channel of the tracker for consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none

module tsto_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic [2:0]   m_tuser,
    input wire logic         m_tlast
);

    // The output register comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Timeouts are never the final beat; every other kind closes its command.
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser != tsto_pkg::KIND_TIMEOUT)))
        else $error("last flag does not match result kind");

    a_ffull: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[120] |->
            m_tuser == tsto_pkg::KIND_TIMEOUT && m_tdata[111:96] == 16'd0)
        else $error("failure table full flag on a bad beat");

endmodule

bind tcp_syn_timeout_tracker_unit tsto_checker u_tsto_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
